// File: sv/pfde_pkg.sv
`timescale 1ns / 1ps
// pfde_pkg: shared types, constants and key square helpers for the playfair
// digraph encryptor; no dependencies
package pfde_pkg;

   localparam int KEY_DIM = 5;

   // row/column index of a key square cell
   typedef logic [2:0] cell_idx_type;

   // five rows, column k of a row at bits 8k+7..8k
   typedef logic [KEY_DIM-1:0][39:0] key_square_type;

   localparam cell_idx_type PAD_ROW  = 3'd3;
   localparam cell_idx_type PAD_COL  = 3'd3;
   localparam cell_idx_type LAST_IDX = 3'd4;

   localparam logic [39:0] KEY_ROW_ZERO_RST  = 40'd336437920082;
   localparam logic [39:0] KEY_ROW_ONE_RST   = 40'd306121622594;
   localparam logic [39:0] KEY_ROW_TWO_RST   = 40'd331992484168;
   localparam logic [39:0] KEY_ROW_THREE_RST = 40'd362175090767;
   localparam logic [39:0] KEY_ROW_FOUR_RST  = 40'd388046018390;
   localparam logic [7:0]  MARKER_RST        = 8'd88;

   typedef enum logic [2:0] {
      CSR_KEY_ROW_ZERO  = 3'd0,
      CSR_KEY_ROW_ONE   = 3'd1,
      CSR_KEY_ROW_TWO   = 3'd2,
      CSR_KEY_ROW_THREE = 3'd3,
      CSR_KEY_ROW_FOUR  = 3'd4,
      CSR_MARKER        = 3'd5
   } csr_index_type;

   // one complete pair waiting for encryption
   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic       pad;
      logic       last;
   } pair_job_type;

   // both cipher bytes of one pair
   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic       not_in_key;
      logic       last_byte;
   } cipher_pair_type;

   function automatic logic [7:0] key_cell(key_square_type key, cell_idx_type row,
                                           cell_idx_type col);
      logic [5:0] lsb;
      lsb = {col, 3'b000};
      return key[row][lsb +: 8];
   endfunction

endpackage

// File: sv/pfde_if.sv
`timescale 1ns / 1ps
// channel interfaces of the playfair digraph encryptor
// no dependencies
interface pfde_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] message_byte;
   logic       end_of_message;
   modport source (output valid, output message_byte, output end_of_message, input ready);
   modport sink (input valid, input message_byte, input end_of_message, output ready);
endinterface

interface pfde_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] cipher_byte;
   logic       not_in_key;
   logic       last_byte;
   modport source (output valid, output cipher_byte, output not_in_key, output last_byte,
                   input ready);
   modport sink (input valid, input cipher_byte, input not_in_key, input last_byte,
                 output ready);
endinterface

interface pfde_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [39:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/pfde_csr.sv
`timescale 1ns / 1ps
// pfde_csr: key square rows and same-cell marker registers
// depends on pfde_pkg and pfde_csr_if
module pfde_csr import pfde_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   pfde_csr_if.sink       csr_ch,
   output key_square_type key_square,
   output logic [7:0]     marker
);

   key_square_type key_ff, key_in;
   logic [7:0]     marker_ff, marker_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      key_in    = key_ff;
      marker_in = marker_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_KEY_ROW_ZERO:  key_in[0] = csr_ch.data;
            CSR_KEY_ROW_ONE:   key_in[1] = csr_ch.data;
            CSR_KEY_ROW_TWO:   key_in[2] = csr_ch.data;
            CSR_KEY_ROW_THREE: key_in[3] = csr_ch.data;
            CSR_KEY_ROW_FOUR:  key_in[4] = csr_ch.data;
            CSR_MARKER:        marker_in = csr_ch.data[7:0];
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff    <= {KEY_ROW_FOUR_RST, KEY_ROW_THREE_RST, KEY_ROW_TWO_RST,
                       KEY_ROW_ONE_RST, KEY_ROW_ZERO_RST};
         marker_ff <= MARKER_RST;
      end else begin
         key_ff    <= key_in;
         marker_ff <= marker_in;
      end
   end

   assign key_square = key_ff;
   assign marker     = marker_ff;

endmodule

// File: sv/pfde_pair.sv
`timescale 1ns / 1ps
// pfde_pair: input register stage, holds the first byte and forms pair jobs
// depends on pfde_pkg and pfde_req_if
module pfde_pair import pfde_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   pfde_req_if.sink       req_ch,
   input  key_square_type key_square,
   input  logic           pair_take,
   output logic           job_valid,
   output pair_job_type   job
);

   logic         job_valid_ff, job_valid_in;
   pair_job_type job_ff, job_in;
   logic [7:0]   held_ff, held_in;
   logic         holding_ff, holding_in;
   logic         req_accept;

   assign req_ch.ready = !job_valid_ff || pair_take;
   assign req_accept   = req_ch.valid && req_ch.ready;

   always_comb begin
      job_valid_in = job_valid_ff && !pair_take;
      job_in       = job_ff;
      held_in      = held_ff;
      holding_in   = holding_ff;
      if (req_accept) begin
         if (holding_ff) begin
            job_in       = '{first_byte: held_ff, second_byte: req_ch.message_byte,
                             pad: 1'b0, last: req_ch.end_of_message};
            job_valid_in = 1'b1;
            holding_in   = 1'b0;
         end else if (req_ch.end_of_message) begin
            // odd final byte pairs with the pad cell
            job_in       = '{first_byte: req_ch.message_byte,
                             second_byte: key_cell(key_square, PAD_ROW, PAD_COL),
                             pad: 1'b1, last: 1'b1};
            job_valid_in = 1'b1;
         end else begin
            held_in    = req_ch.message_byte;
            holding_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         holding_ff   <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         holding_ff   <= holding_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      held_ff <= held_in;
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

   // a waiting job is never dropped
   a_job_kept: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && !pair_take |=> job_valid_ff && $stable(job_ff))
      else $error("pair job lost before being taken");

   // second byte completes the pair and clears the hold
   a_pair_formed: assert property (@(posedge clock) disable iff (reset)
      req_accept && holding_ff |=> !holding_ff && job_valid_ff)
      else $error("second byte did not form a pair");

   // non-final first byte is held without producing a job
   a_first_held: assert property (@(posedge clock) disable iff (reset)
      req_accept && !holding_ff && !req_ch.end_of_message && !pair_take && !job_valid_ff
      |=> holding_ff && !job_valid_ff)
      else $error("first byte not held");

endmodule

// File: sv/pfde_cipher.sv
`timescale 1ns / 1ps
// pfde_cipher: combinational key square search and playfair pair rules
// depends on pfde_pkg
module pfde_cipher import pfde_pkg::*; (
   input  key_square_type  key_square,
   input  logic [7:0]      marker,
   input  pair_job_type    job,
   output cipher_pair_type result
);

   typedef struct packed {
      logic         found;
      cell_idx_type row;
      cell_idx_type col;
   } cell_pos_type;

   // parallel compare of all 25 cells, last match in row-major order wins
   function automatic cell_pos_type locate_byte(key_square_type key, logic [7:0] value);
      cell_pos_type pos;
      pos = '{found: 1'b0, row: '0, col: '0};
      for (int r = 0; r < KEY_DIM; r++) begin
         for (int c = 0; c < KEY_DIM; c++) begin
            if (key[r][8*c +: 8] == value) begin
               pos.found = 1'b1;
               pos.row   = cell_idx_type'(r);
               pos.col   = cell_idx_type'(c);
            end
         end
      end
      return pos;
   endfunction

   function automatic cell_idx_type wrap_inc(cell_idx_type v);
      return (v == LAST_IDX) ? '0 : cell_idx_type'(v + 3'd1);
   endfunction

   cell_pos_type pos_a, pos_b;

   always_comb begin
      pos_a = locate_byte(key_square, job.first_byte);
      pos_b = job.pad ? cell_pos_type'{found: 1'b1, row: PAD_ROW, col: PAD_COL}
                      : locate_byte(key_square, job.second_byte);

      result.not_in_key = !(pos_a.found && pos_b.found);
      result.last_byte  = job.last;
      if (result.not_in_key) begin
         result.first_byte  = job.first_byte;
         result.second_byte = job.second_byte;
      end else if (pos_a.row == pos_b.row && pos_a.col == pos_b.col) begin
         result.first_byte  = job.first_byte;
         result.second_byte = marker;
      end else if (pos_a.row == pos_b.row) begin
         result.first_byte  = key_cell(key_square, pos_a.row, wrap_inc(pos_a.col));
         result.second_byte = key_cell(key_square, pos_b.row, wrap_inc(pos_b.col));
      end else if (pos_a.col == pos_b.col) begin
         result.first_byte  = key_cell(key_square, wrap_inc(pos_a.row), pos_a.col);
         result.second_byte = key_cell(key_square, wrap_inc(pos_b.row), pos_b.col);
      end else begin
         // rectangle: swap columns
         result.first_byte  = key_cell(key_square, pos_a.row, pos_b.col);
         result.second_byte = key_cell(key_square, pos_b.row, pos_a.col);
      end
   end

endmodule

// File: sv/pfde_rsp.sv
`timescale 1ns / 1ps
// pfde_rsp: result register, sends the two cipher bytes of a pair in order
// depends on pfde_pkg and pfde_rsp_if
module pfde_rsp import pfde_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            job_valid,
   input  cipher_pair_type result,
   output logic            pair_take,
   pfde_rsp_if.source      rsp_ch
);

   // number of bytes of the held pair still to send
   logic [1:0]      left_ff, left_in;
   cipher_pair_type pend_ff, pend_in;
   logic            rsp_accept;

   assign rsp_ch.valid = (left_ff != 2'd0);
   assign rsp_accept   = rsp_ch.valid && rsp_ch.ready;
   // load as soon as the last byte of the previous pair leaves
   assign pair_take    = job_valid && (left_ff == 2'd0 || (left_ff == 2'd1 && rsp_ch.ready));

   assign rsp_ch.cipher_byte = (left_ff == 2'd2) ? pend_ff.first_byte : pend_ff.second_byte;
   assign rsp_ch.not_in_key  = pend_ff.not_in_key;
   assign rsp_ch.last_byte   = (left_ff == 2'd1) && pend_ff.last_byte;

   always_comb begin
      left_in = left_ff;
      pend_in = pend_ff;
      if (pair_take) begin
         left_in = 2'd2;
         pend_in = result;
      end else if (rsp_accept) begin
         left_in = left_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 2'd0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

endmodule

// File: sv/playfair_digraph_encrypt_unit.sv
`timescale 1ns / 1ps
// playfair_digraph_encrypt_unit: top level of the playfair digraph encryptor
// depends on pfde_pkg, pfde_if, pfde_csr, pfde_pair, pfde_cipher, pfde_rsp
//
// Takes one message byte per cycle and sends one cipher byte per cycle, so a
// message streams through at one byte per clock in each direction while the
// receiver does not stall. Bytes are paired in an input register; a completed
// pair (or an odd final byte padded with key cell row 3, column 3) goes
// through a single combinational pass of 25 parallel cell compares and the
// playfair rules into a result register, which sends the pair's two bytes in
// order. A pair passes the input register and then the result register; the
// result register loads the next pair in the cycle the last byte of the
// current one is taken, so no bubble opens between pairs. An odd final byte
// yields two cipher bytes for a single transaction, so with the output
// running flat out the input waits on the output. Key rows and the
// same-cell marker are written through the csr channel, which is always
// ready, and are only to be changed while no pair is in flight.
module playfair_digraph_encrypt_unit import pfde_pkg::*; (
   input logic        clock,
   input logic        reset,
   pfde_req_if.sink   req_ch,
   pfde_rsp_if.source rsp_ch,
   pfde_csr_if.sink   csr_ch
);

   key_square_type  key_square;
   logic [7:0]      marker;
   logic            pair_take;
   logic            job_valid;
   pair_job_type    job;
   cipher_pair_type result;

   pfde_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_ch     (csr_ch),
      .key_square (key_square),
      .marker     (marker)
   );

   pfde_pair u_pair (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .key_square (key_square),
      .pair_take  (pair_take),
      .job_valid  (job_valid),
      .job        (job)
   );

   pfde_cipher u_cipher (
      .key_square (key_square),
      .marker     (marker),
      .job        (job),
      .result     (result)
   );

   pfde_rsp u_rsp (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .result    (result),
      .pair_take (pair_take),
      .rsp_ch    (rsp_ch)
   );

endmodule

// File: verif/tb_playfair_digraph_encrypt_unit.sv
`timescale 1ns / 1ps
// tb_playfair_digraph_encrypt_unit: self-checking bench for the playfair digraph encryptor
// depends on pfde_pkg, pfde_if and playfair_digraph_encrypt_unit
module tb_playfair_digraph_encrypt_unit;
   import pfde_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned TAIL_CYCLES   = 8;
   localparam int unsigned MAX_PRINTS    = 50;
   localparam logic [2:0]  CSR_SPARE_LO  = 3'd6;
   localparam logic [2:0]  CSR_SPARE_HI  = 3'd7;

   typedef struct packed {
      logic [7:0] plain;
      logic       eom;
      logic       typed;
      logic [7:0] want0;
      logic [7:0] want1;
      logic       want_nik;
   } plain_row_type;

   typedef struct packed {
      logic [7:0] cipher;
      logic       nik;
      logic       last;
   } cipher_expect_type;

   typedef enum {SQ_DISTINCT, SQ_ZEROS, SQ_ONES, SQ_REPEATS} square_kind_type;

   // pairs against the reset key square:
   //   R A C U N / B D E F G / H I K L M / O P Q S T / V W X Y Z
   localparam plain_row_type DIRECTED_ROWS [0:26] = '{
      '{"R", 1'b0, 1'b0, 8'h00, 8'h00, 1'b0}, '{"A", 1'b0, 1'b1, "A", "C", 1'b0},
      '{"R", 1'b0, 1'b0, 8'h00, 8'h00, 1'b0}, '{"B", 1'b0, 1'b1, "B", "H", 1'b0},
      '{"A", 1'b0, 1'b0, 8'h00, 8'h00, 1'b0}, '{"E", 1'b0, 1'b1, "C", "D", 1'b0},
      '{"N", 1'b0, 1'b0, 8'h00, 8'h00, 1'b0}, '{"U", 1'b0, 1'b1, "R", "N", 1'b0},
      '{"Z", 1'b0, 1'b0, 8'h00, 8'h00, 1'b0}, '{"N", 1'b0, 1'b1, "N", "G", 1'b0},
      '{"K", 1'b0, 1'b0, 8'h00, 8'h00, 1'b0}, '{"K", 1'b0, 1'b1, "K", "X", 1'b0},
      '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0}, '{"A", 1'b0, 1'b1, 8'h00, "A", 1'b1},
      // row three, second byte shifts into the pad cell
      '{"P", 1'b0, 1'b0, 8'h00, 8'h00, 1'b0}, '{"Q", 1'b0, 1'b1, "Q", "S", 1'b0},
      '{"M", 1'b0, 1'b0, 8'h00, 8'h00, 1'b0}, '{"V", 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
      // message ends: odd final bytes pad with S, others close a pair
      '{"A", 1'b1, 1'b1, "U", "P", 1'b0},
      '{"S", 1'b1, 1'b1, "S", "X", 1'b0},
      '{8'h01, 1'b1, 1'b1, 8'h01, "S", 1'b1},
      '{"T", 1'b0, 1'b0, 8'h00, 8'h00, 1'b0}, '{"Y", 1'b1, 1'b1, "S", "Z", 1'b0},
      '{"B", 1'b0, 1'b0, 8'h00, 8'h00, 1'b0}, '{8'hFF, 1'b1, 1'b1, "B", 8'hFF, 1'b1},
      '{"T", 1'b1, 1'b1, "O", "T", 1'b0},
      '{"Y", 1'b1, 1'b1, "U", "Y", 1'b0}
   };

   localparam square_kind_type PHASE_KIND [0:5] = '{SQ_DISTINCT, SQ_ZEROS, SQ_DISTINCT,
                                                   SQ_ONES, SQ_REPEATS, SQ_DISTINCT};
   localparam int unsigned PHASE_ITEMS [0:5] = '{150, 60, 150, 60, 140, 140};
   localparam int unsigned SEND_IDLE_PCT [0:3] = '{0, 76, 0, 33};
   localparam int unsigned RECV_IDLE_PCT [0:3] = '{0, 0, 76, 33};

   logic clock = 1'b0;
   logic reset;

   pfde_req_if req_ch ();
   pfde_rsp_if rsp_ch ();
   pfde_csr_if csr_ch ();

   playfair_digraph_encrypt_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor state
   key_square_type key_square = {KEY_ROW_FOUR_RST, KEY_ROW_THREE_RST, KEY_ROW_TWO_RST,
                                 KEY_ROW_ONE_RST, KEY_ROW_ZERO_RST};
   logic [7:0] marker_byte = MARKER_RST;
   logic [7:0] held_plain = 8'h00;
   bit first_waiting = 1'b0;

   cipher_expect_type pending_cipher[$];
   int unsigned mismatch_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   logic rsp_hold = 1'b0;
   event rsp_hold_ev;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("playfair_digraph_encrypt_unit regression: fail");
      $finish;
   end

   function automatic logic [7:0] square_byte(int unsigned row, int unsigned col);
      return key_square[row][8 * col +: 8];
   endfunction

   function automatic bit find_byte(logic [7:0] b, output int unsigned row,
                                    output int unsigned col);
      bit hit;
      hit = 1'b0;
      row = 0;
      col = 0;
      for (int unsigned i = 0; i < KEY_DIM; i++)
         for (int unsigned j = 0; j < KEY_DIM; j++)
            if (square_byte(i, j) == b) begin
               row = i;
               col = j;
               hit = 1'b1;
            end
      return hit;
   endfunction

   function automatic void cipher_pair(logic [7:0] a, logic [7:0] b, bit pad,
                                       output logic [7:0] c0, output logic [7:0] c1,
                                       output logic nik);
      int unsigned ra, ca, rb, cb;
      bit hit_a, hit_b;
      hit_a = find_byte(a, ra, ca);
      if (pad) begin
         rb = PAD_ROW;
         cb = PAD_COL;
         hit_b = 1'b1;
      end else begin
         hit_b = find_byte(b, rb, cb);
      end
      nik = 1'b0;
      if (!hit_a || !hit_b) begin
         c0 = a;
         c1 = b;
         nik = 1'b1;
      end else if (ra == rb && ca == cb) begin
         c0 = a;
         c1 = marker_byte;
      end else if (ra == rb) begin
         c0 = square_byte(ra, (ca + 1) % KEY_DIM);
         c1 = square_byte(rb, (cb + 1) % KEY_DIM);
      end else if (ca == cb) begin
         c0 = square_byte((ra + 1) % KEY_DIM, ca);
         c1 = square_byte((rb + 1) % KEY_DIM, cb);
      end else begin
         c0 = square_byte(ra, cb);
         c1 = square_byte(rb, ca);
      end
   endfunction

   // returns 1 when the byte completes a pair
   function automatic bit encrypt_plain(logic [7:0] plain, logic eom, output logic [7:0] c0,
                                        output logic [7:0] c1, output logic nik,
                                        output logic last);
      c0 = 8'h00;
      c1 = 8'h00;
      nik = 1'b0;
      last = eom;
      if (first_waiting) begin
         first_waiting = 1'b0;
         cipher_pair(held_plain, plain, 1'b0, c0, c1, nik);
         return 1'b1;
      end
      if (eom) begin
         cipher_pair(plain, square_byte(PAD_ROW, PAD_COL), 1'b1, c0, c1, nik);
         return 1'b1;
      end
      held_plain = plain;
      first_waiting = 1'b1;
      return 1'b0;
   endfunction

   function automatic key_square_type build_square(square_kind_type kind);
      key_square_type sq;
      bit used [256];
      logic [7:0] v;
      for (int i = 0; i < KEY_DIM * KEY_DIM; i++) begin
         case (kind)
            SQ_ZEROS: v = 8'h00;
            SQ_ONES: v = 8'hFF;
            SQ_REPEATS: v = 8'h41 + 8'($urandom_range(0, 7));
            default: begin
               v = 8'($urandom_range(0, 255));
               while (used[v]) v = 8'($urandom_range(0, 255));
               used[v] = 1'b1;
            end
         endcase
         sq[i / KEY_DIM][8 * (i % KEY_DIM) +: 8] = v;
      end
      return sq;
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
   endtask

   task automatic take_cipher();
      cipher_expect_type want;
      if (pending_cipher.size() == 0) begin
         report_mismatch("cipher byte with nothing pending", rsp_ch.cipher_byte, 8'h00);
         return;
      end
      want = pending_cipher.pop_front();
      if (rsp_ch.cipher_byte !== want.cipher)
         report_mismatch("cipher_byte", rsp_ch.cipher_byte, want.cipher);
      if (rsp_ch.not_in_key !== want.nik)
         report_mismatch("not_in_key", 8'(rsp_ch.not_in_key), 8'(want.nik));
      if (rsp_ch.last_byte !== want.last)
         report_mismatch("last_byte", 8'(rsp_ch.last_byte), 8'(want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) take_cipher();
         rsp_ch.ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // long receiver stall so the block backs up into its input
   initial begin
      forever begin
         @(rsp_hold_ev);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   task automatic send_plain(logic [7:0] plain, logic eom, bit typed, logic [7:0] want0,
                             logic [7:0] want1, logic want_nik, bit no_gaps);
      logic [7:0] c0, c1;
      logic nik, last;
      if (!no_gaps)
         while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      req_ch.valid <= 1'b1;
      req_ch.message_byte <= plain;
      req_ch.end_of_message <= eom;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (encrypt_plain(plain, eom, c0, c1, nik, last)) begin
         if (typed) begin
            c0 = want0;
            c1 = want1;
            nik = want_nik;
         end
         pending_cipher.push_back('{c0, nik, 1'b0});
         pending_cipher.push_back('{c1, nik, last});
      end
   endtask

   task automatic send_message(int unsigned len, bit no_gaps);
      logic [7:0] plain;
      for (int unsigned k = 0; k < len; k++) begin
         if (first_waiting && $urandom_range(0, 9) == 0)
            plain = held_plain;
         else if ($urandom_range(0, 99) < 85)
            plain = square_byte($urandom_range(0, 4), $urandom_range(0, 4));
         else
            plain = 8'($urandom_range(0, 255));
         send_plain(plain, k == len - 1, 1'b0, 8'h00, 8'h00, 1'b0, no_gaps);
      end
   endtask

   task automatic drain_cipher();
      req_ch.valid <= 1'b0;
      while (pending_cipher.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [39:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_KEY_ROW_ZERO, CSR_KEY_ROW_ONE, CSR_KEY_ROW_TWO, CSR_KEY_ROW_THREE,
         CSR_KEY_ROW_FOUR: key_square[idx] = data;
         CSR_MARKER: marker_byte = data[7:0];
         default: ;
      endcase
   endtask

   task automatic program_square(key_square_type sq, logic [39:0] marker_data);
      write_csr(CSR_KEY_ROW_ZERO, sq[0]);
      write_csr(CSR_KEY_ROW_ONE, sq[1]);
      write_csr(CSR_KEY_ROW_TWO, sq[2]);
      write_csr(CSR_KEY_ROW_THREE, sq[3]);
      write_csr(CSR_KEY_ROW_FOUR, sq[4]);
      write_csr(CSR_MARKER, marker_data);
      // spare indexes must leave the key alone
      write_csr(CSR_SPARE_LO, 40'({$urandom, $urandom}));
      write_csr(CSR_SPARE_HI, 40'({$urandom, $urandom}));
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      int unsigned sent;
      int unsigned msg_count;
      int unsigned len;
      logic [39:0] marker_data;

      req_ch.valid <= 1'b0;
      req_ch.message_byte <= 8'h00;
      req_ch.end_of_message <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_KEY_ROW_ZERO;
      csr_ch.data <= 40'h0;
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         send_plain(DIRECTED_ROWS[i].plain, DIRECTED_ROWS[i].eom, DIRECTED_ROWS[i].typed,
                    DIRECTED_ROWS[i].want0, DIRECTED_ROWS[i].want1,
                    DIRECTED_ROWS[i].want_nik, 1'b1);

      for (int p = 0; p < 6; p++) begin
         drain_cipher();
         repeat (SETTLE_CYCLES) @(posedge clock);
         case (PHASE_KIND[p])
            SQ_ZEROS: marker_data = 40'h0;
            SQ_ONES: marker_data = 40'hFF_FFFF_FFFF;
            default: marker_data = 40'({$urandom, $urandom});
         endcase
         program_square(build_square(PHASE_KIND[p]), marker_data);
         send_idle_pct = SEND_IDLE_PCT[p % 4];
         recv_idle_pct = RECV_IDLE_PCT[p % 4];
         if (p == 2) -> rsp_hold_ev;
         sent = 0;
         msg_count = 0;
         while (sent < PHASE_ITEMS[p]) begin
            len = $urandom_range(1, 9);
            send_message(len, $urandom_range(0, 5) == 0);
            sent += len;
            msg_count++;
            if (msg_count == 3 || $urandom_range(0, 7) == 0) drain_cipher();
         end
      end

      drain_cipher();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("playfair_digraph_encrypt_unit regression: pass");
      else
         $display("playfair_digraph_encrypt_unit regression: fail");
      $finish;
   end

endmodule

// File: files.f
sv/pfde_pkg.sv
sv/pfde_if.sv
sv/pfde_csr.sv
sv/pfde_pair.sv
sv/pfde_cipher.sv
sv/pfde_rsp.sv
sv/playfair_digraph_encrypt_unit.sv
verif/tb_playfair_digraph_encrypt_unit.sv
